@@ sv/assert_macros.svh @@
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Check an implication in the following cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/pps_pkg.sv @@
// Shared types, constants and tables for the pure pursuit steering core
package pps_pkg;
    localparam int COORD_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int LOOK_WIDTH   = 15;
    localparam int SPEED_WIDTH  = 12;
    localparam int ANGLE_WIDTH  = 16;
    localparam int SQ_WIDTH     = 2 * COORD_WIDTH;
    localparam int DIST_WIDTH   = 2 * COORD_WIDTH + 1;
    localparam int DVS_WIDTH    = DIST_WIDTH + 7;
    localparam int NUM_WIDTH    = 17 + COORD_WIDTH + 16;
    localparam int QUO_WIDTH    = NUM_WIDTH;
    localparam int DIV_CNT_W    = $clog2(QUO_WIDTH + 1);
    localparam int CORDIC_USED  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int CRD_CNT_W    = $clog2(CORDIC_USED + 1);
    localparam int CRD_WIDTH    = QUO_WIDTH + 4;
    localparam int Z_WIDTH      = 26;
    localparam int ANGLE_MAX    = 23040;
    localparam int ADDR_LOOKAHEAD = 0;
    localparam int ADDR_CRUISE    = 1;

    typedef enum logic [2:0] {
        ST_SCAN, ST_DIV, ST_SCALE, ST_CORDIC, ST_FINISH, ST_OUT
    } state_t;

    typedef struct packed {
        logic scan;
        logic clear;
        logic div_start;
        logic div_step;
        logic scale;
        logic crd_start;
        logic crd_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic crd_done;
    } stat_t;

    function automatic logic [Z_WIDTH-1:0] atan_deg(input logic [4:0] i);
        case (i)
            5'd0:  atan_deg = Z_WIDTH'(2949120);
            5'd1:  atan_deg = Z_WIDTH'(1740967);
            5'd2:  atan_deg = Z_WIDTH'(919879);
            5'd3:  atan_deg = Z_WIDTH'(466945);
            5'd4:  atan_deg = Z_WIDTH'(234379);
            5'd5:  atan_deg = Z_WIDTH'(117304);
            5'd6:  atan_deg = Z_WIDTH'(58666);
            5'd7:  atan_deg = Z_WIDTH'(29335);
            5'd8:  atan_deg = Z_WIDTH'(14668);
            5'd9:  atan_deg = Z_WIDTH'(7334);
            5'd10: atan_deg = Z_WIDTH'(3667);
            5'd11: atan_deg = Z_WIDTH'(1833);
            5'd12: atan_deg = Z_WIDTH'(917);
            5'd13: atan_deg = Z_WIDTH'(458);
            5'd14: atan_deg = Z_WIDTH'(229);
            5'd15: atan_deg = Z_WIDTH'(115);
            5'd16: atan_deg = Z_WIDTH'(57);
            5'd17: atan_deg = Z_WIDTH'(29);
            5'd18: atan_deg = Z_WIDTH'(14);
            5'd19: atan_deg = Z_WIDTH'(7);
            5'd20: atan_deg = Z_WIDTH'(4);
            5'd21: atan_deg = Z_WIDTH'(2);
            5'd22: atan_deg = Z_WIDTH'(1);
            default: atan_deg = '0;
        endcase
    endfunction
endpackage

@@ sv/pps_ctrl.sv @@
// Controller state machine for the pure pursuit steering core
module pps_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_last_point,
    output logic            m_valid,
    input  logic            m_ready,
    input  pps_pkg::stat_t  stat,
    output pps_pkg::cmd_t   cmd
);
    import pps_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SCAN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_SCAN: begin
                s_ready  = 1'b1;
                cmd.scan = s_valid;
                if (s_valid && s_last_point) begin
                    state_next    = ST_DIV;
                    cmd.div_start = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.crd_step = 1'b1;
                if (stat.crd_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            default: state_next = ST_SCAN;
        endcase
        cmd.crd_start = cmd.scale;
    end
endmodule

@@ sv/pps_datapath.sv @@
// Datapath: point scan, restoring divider, CORDIC and output registers
module pps_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pps_pkg::cmd_t                        cmd,
    output pps_pkg::stat_t                       stat,
    input  logic [pps_pkg::LOOK_WIDTH-1:0]       lookahead_dist,
    input  logic [pps_pkg::SPEED_WIDTH-1:0]      cruise_speed,
    input  logic                                 s_has_point,
    input  logic signed [pps_pkg::COORD_WIDTH-1:0] s_point_x,
    input  logic signed [pps_pkg::COORD_WIDTH-1:0] s_point_y,
    output logic [pps_pkg::SPEED_WIDTH-1:0]      m_linear_speed,
    output logic signed [pps_pkg::ANGLE_WIDTH-1:0] m_steer_angle,
    output logic                                 m_target_found
);
    import pps_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic                 found_reg;
    logic signed [CW-1:0] tx_reg, ty_reg;
    logic [CW-1:0]        ax, ay;
    logic [DIST_WIDTH-1:0] pt_dist, look2;
    logic                 hit, hit_now;

    assign ax      = s_point_x[CW-1] ? CW'(-s_point_x) : CW'(s_point_x);
    assign ay      = s_point_y[CW-1] ? CW'(-s_point_y) : CW'(s_point_y);
    assign pt_dist = DIST_WIDTH'(SQ_WIDTH'(ax) * SQ_WIDTH'(ax))
                   + DIST_WIDTH'(SQ_WIDTH'(ay) * SQ_WIDTH'(ay));
    assign look2   = DIST_WIDTH'(SQ_WIDTH'(lookahead_dist) * SQ_WIDTH'(lookahead_dist));
    assign hit     = s_has_point && !found_reg && !s_point_x[CW-1] && (pt_dist > look2);
    assign hit_now = cmd.scan && hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.clear) begin
            found_reg <= 1'b0;
        end else if (hit_now) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit_now) begin
            tx_reg <= s_point_x;
            ty_reg <= s_point_y;
        end
    end

    // Divider: quotient = (78336*|y| << 16) / (100*d), one bit per cycle.
    // A target on the last point itself is taken straight from the inputs.
    logic [CW-1:0]         tax, tay, ay_sel;
    logic [DIST_WIDTH-1:0] t_dist, d_sel;
    logic [DVS_WIDTH-1:0]  dvs_reg;
    logic [NUM_WIDTH-1:0]  num_reg;
    logic [DVS_WIDTH:0]    rem_reg, rem_sh, rem_sub;
    logic [DIV_CNT_W-1:0]  dcnt_reg;

    assign tax     = tx_reg[CW-1] ? CW'(-tx_reg) : CW'(tx_reg);
    assign tay     = ty_reg[CW-1] ? CW'(-ty_reg) : CW'(ty_reg);
    assign t_dist  = DIST_WIDTH'(SQ_WIDTH'(tax) * SQ_WIDTH'(tax))
                   + DIST_WIDTH'(SQ_WIDTH'(tay) * SQ_WIDTH'(tay));
    assign d_sel   = hit_now ? pt_dist : t_dist;
    assign ay_sel  = hit_now ? ay : tay;
    assign rem_sh  = {rem_reg[DVS_WIDTH-1:0], num_reg[NUM_WIDTH-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            // 100*d and 78336*|y|*2^16 as shift-and-add
            dvs_reg  <= (DVS_WIDTH'(d_sel) << 6) + (DVS_WIDTH'(d_sel) << 5)
                      + (DVS_WIDTH'(d_sel) << 2);
            num_reg  <= (NUM_WIDTH'(ay_sel) << 32) + (NUM_WIDTH'(ay_sel) << 29)
                      + (NUM_WIDTH'(ay_sel) << 28) + (NUM_WIDTH'(ay_sel) << 25);
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step && !stat.div_done) begin
            if (!rem_sub[DVS_WIDTH]) begin
                rem_reg <= rem_sub;
                num_reg <= {num_reg[NUM_WIDTH-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                num_reg <= {num_reg[NUM_WIDTH-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end
    assign stat.div_done = (dcnt_reg == DIV_CNT_W'(QUO_WIDTH));

    // CORDIC vectoring on (1.0, +-t)
    logic signed [CRD_WIDTH-1:0] cx_reg, cy_reg, sx, sy;
    logic signed [Z_WIDTH-1:0]   z_reg, zr;
    logic [CRD_CNT_W-1:0]        ccnt_reg;

    assign sx = cx_reg >>> ccnt_reg;
    assign sy = cy_reg >>> ccnt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.crd_start) begin
            cx_reg   <= CRD_WIDTH'(65536);
            cy_reg   <= ty_reg[CW-1] ? -CRD_WIDTH'(num_reg) : CRD_WIDTH'(num_reg);
            z_reg    <= '0;
            ccnt_reg <= '0;
        end else if (cmd.crd_step && !stat.crd_done) begin
            if (!cy_reg[CRD_WIDTH-1]) begin
                cx_reg <= cx_reg + sy;
                cy_reg <= cy_reg - sx;
                z_reg  <= z_reg + $signed(atan_deg(5'(ccnt_reg)));
            end else begin
                cx_reg <= cx_reg - sy;
                cy_reg <= cy_reg + sx;
                z_reg  <= z_reg - $signed(atan_deg(5'(ccnt_reg)));
            end
            ccnt_reg <= ccnt_reg + 1'b1;
        end
    end
    assign stat.crd_done = (ccnt_reg == CRD_CNT_W'(CORDIC_USED));

    assign zr = (z_reg + Z_WIDTH'(128)) >>> 8;

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_target_found <= found_reg;
            m_linear_speed <= found_reg ? cruise_speed : '0;
            if (!found_reg) begin
                m_steer_angle <= '0;
            end else if (zr > Z_WIDTH'(ANGLE_MAX)) begin
                m_steer_angle <= ANGLE_WIDTH'(ANGLE_MAX);
            end else if (zr < -Z_WIDTH'(ANGLE_MAX)) begin
                m_steer_angle <= -ANGLE_WIDTH'(ANGLE_MAX);
            end else begin
                m_steer_angle <= ANGLE_WIDTH'(zr);
            end
        end
    end
endmodule

@@ sv/pure_pursuit_steering_core.sv @@
// Top level of the pure pursuit steering core
// Throughput: one point request per cycle while scanning the trajectory.
// Sequence: a taken last-point request starts the 49-step one-bit-per-cycle
// divider, then the scale state starts the 16-step CORDIC and the finish state
// registers the output command.
// Reset: synchronous active low; clears scan state, loads lookahead 1536 and
// cruise speed 700.
module pure_pursuit_steering_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [0:0]                           cfg_index,
    input  logic [pps_pkg::LOOK_WIDTH-1:0]       cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_has_point,
    input  logic signed [pps_pkg::COORD_WIDTH-1:0] s_point_x,
    input  logic signed [pps_pkg::COORD_WIDTH-1:0] s_point_y,
    input  logic                                 s_last_point,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [pps_pkg::SPEED_WIDTH-1:0]      m_linear_speed,
    output logic signed [pps_pkg::ANGLE_WIDTH-1:0] m_steer_angle,
    output logic                                 m_target_found
);
    import pps_pkg::*;

    logic [LOOK_WIDTH-1:0]  look_reg;
    logic [SPEED_WIDTH-1:0] cruise_reg;
    cmd_t  cmd;
    stat_t stat;

    // Hold configuration; only legal while idle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            look_reg   <= LOOK_WIDTH'(1536);
            cruise_reg <= SPEED_WIDTH'(700);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                1'(ADDR_LOOKAHEAD): look_reg   <= cfg_data;
                1'(ADDR_CRUISE):    cruise_reg <= cfg_data[SPEED_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    pps_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_last_point,
        .m_valid, .m_ready, .stat, .cmd
    );

    pps_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .lookahead_dist(look_reg), .cruise_speed(cruise_reg),
        .s_has_point, .s_point_x, .s_point_y,
        .m_linear_speed, .m_steer_angle, .m_target_found
    );
endmodule

@@ sv/pps_checker.sv @@
// Port-level checker for the pure pursuit steering core, bound to the top
`include "assert_macros.svh"
module pps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_point,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_linear_speed,
    input logic signed [15:0] m_steer_angle,
    input logic        m_target_found
);
    `ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, m_valid, !s_ready, "request taken while busy")
    `ASSERT_IMPL(a_stop_zero, aclk, aresetn, m_valid && !m_target_found, m_linear_speed == 12'd0 && m_steer_angle == 16'sd0, "stop command not zero")
    `ASSERT_IMPL(a_angle_range, aclk, aresetn, m_valid, m_steer_angle <= 16'sd23040 && m_steer_angle >= -16'sd23040, "angle out of range")
    `ASSERT_NEXT(a_last_busy, aclk, aresetn, s_valid && s_ready && s_last_point, !s_ready, "scan kept running after last point")
endmodule

bind pure_pursuit_steering_core pps_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .s_last_point, .m_valid, .m_ready,
    .m_linear_speed, .m_steer_angle, .m_target_found
);

@@ test/tb.sv @@
// Testbench for the pure pursuit steering core: scoreboard, drivers and stimulus
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pps_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int PHASE_ITEMS    = 170;

    typedef struct {
        logic [SPEED_WIDTH-1:0]        speed;
        logic signed [ANGLE_WIDTH-1:0] angle;
        logic                          found;
    } steer_cmd_t;

    // Track the point scan and queue the commands the core must produce
    class steer_scoreboard;
        steer_cmd_t                    pending_cmds[$];
        logic [LOOK_WIDTH-1:0]         lookahead;
        logic [SPEED_WIDTH-1:0]        cruise;
        logic                          latched;
        logic signed [COORD_WIDTH-1:0] tgt_x;
        logic signed [COORD_WIDTH-1:0] tgt_y;
        int                            errors;

        function new();
            lookahead = 15'd1536;
            cruise    = 12'd700;
            latched   = 1'b0;
            tgt_x     = '0;
            tgt_y     = '0;
            errors    = 0;
        endfunction

        function void set_reg(int idx, logic [LOOK_WIDTH-1:0] data);
            if (idx == ADDR_LOOKAHEAD)
                lookahead = data;
            else if (idx == ADDR_CRUISE)
                cruise = data[SPEED_WIDTH-1:0];
        endfunction

        function longint atan_step(int i);
            longint steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                  58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                  229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
            return steps[i];
        endfunction

        // Divide, then CORDIC vectoring on (1.0, 1.02*kappa)
        function logic signed [ANGLE_WIDTH-1:0] steer_of(longint x, longint y);
            longint ax, ay, dist2, ratio, vx, vy, ang, nx;
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            dist2 = ax * ax + ay * ay;
            if (dist2 == 0)
                return '0;
            ratio = ((78336 * ay) << 16) / dist2 / 100;
            vx = 65536;
            vy = (y < 0) ? -ratio : ratio;
            ang = 0;
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                if (vy >= 0) begin
                    nx  = vx + (vy >>> i);
                    vy  = vy - (vx >>> i);
                    ang = ang + atan_step(i);
                end else begin
                    nx  = vx - (vy >>> i);
                    vy  = vy + (vx >>> i);
                    ang = ang - atan_step(i);
                end
                vx = nx;
            end
            ang = (ang + 128) >>> 8;
            if (ang > ANGLE_MAX)
                ang = ANGLE_MAX;
            if (ang < -ANGLE_MAX)
                ang = -ANGLE_MAX;
            return ang[ANGLE_WIDTH-1:0];
        endfunction

        function void note_request(logic has, logic signed [COORD_WIDTH-1:0] x,
                                   logic signed [COORD_WIDTH-1:0] y, logic last);
            longint lx, ly, lim;
            steer_cmd_t cmd;
            lx  = x;
            ly  = y;
            lim = lookahead;
            if (has && !latched && lx >= 0 && lx * lx + ly * ly > lim * lim) begin
                latched = 1'b1;
                tgt_x   = x;
                tgt_y   = y;
            end
            if (!last)
                return;
            if (latched) begin
                cmd.speed = cruise;
                cmd.angle = steer_of(tgt_x, tgt_y);
                cmd.found = 1'b1;
            end else begin
                cmd.speed = '0;
                cmd.angle = '0;
                cmd.found = 1'b0;
            end
            pending_cmds = {pending_cmds, cmd};
            latched = 1'b0;
            tgt_x   = '0;
            tgt_y   = '0;
        endfunction

        function void check_result(logic [SPEED_WIDTH-1:0] speed,
                                   logic signed [ANGLE_WIDTH-1:0] angle, logic found);
            steer_cmd_t want;
            if (pending_cmds.size() == 0) begin
                $error("unexpected command: speed %0d angle %0d found %0d",
                       speed, angle, found);
                errors++;
                return;
            end
            want = pending_cmds.pop_front();
            if (speed !== want.speed) begin
                $error("linear_speed: expected %0d, got %0d", want.speed, speed);
                errors++;
            end
            if (angle !== want.angle) begin
                $error("steer_angle: expected %0d, got %0d", want.angle, angle);
                errors++;
            end
            if (found !== want.found) begin
                $error("target_found: expected %0d, got %0d", want.found, found);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [0:0]                    cfg_index = '0;
    logic [LOOK_WIDTH-1:0]         cfg_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_has_point = 1'b0;
    logic signed [COORD_WIDTH-1:0] s_point_x = '0;
    logic signed [COORD_WIDTH-1:0] s_point_y = '0;
    logic                          s_last_point = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [SPEED_WIDTH-1:0]        m_linear_speed;
    logic signed [ANGLE_WIDTH-1:0] m_steer_angle;
    logic                          m_target_found;

    steer_scoreboard sb = new();
    int  requests_taken = 0;
    int  idle_cycles = 0;
    bit  steady = 1'b0;     // set for stretches without any idling
    int  sent_in_phase;

    always #2 aclk = ~aclk;

    pure_pursuit_steering_core uut (.*);

    // Sample both handshakes on the rising edge, before any register updates
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_has_point, s_point_x, s_point_y, s_last_point);
            requests_taken++;
        end
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_linear_speed, m_steer_angle, m_target_found);
    end

    // Watchdog: end the run if no handshake happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Stall the command output at random
    always @(negedge aclk) begin
        if (steady || $urandom_range(0, 99) < 60)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
    end

    // Present one point request and hold it until accepted
    task automatic send_point(logic has, logic signed [COORD_WIDTH-1:0] x,
                              logic signed [COORD_WIDTH-1:0] y, logic last);
        int gap;
        int target;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_has_point  <= has;
        s_point_x    <= x;
        s_point_y    <= y;
        s_last_point <= last;
        target = requests_taken + 1;
        do @(negedge aclk); while (requests_taken < target);
        sent_in_phase++;
    endtask

    // Let every queued command drain, then let the core settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(int idx, logic [LOOK_WIDTH-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[0:0];
        cfg_data  <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Pick a point: mostly near the lookahead circle, some behind, some anywhere, some empty
    task automatic send_random_point(logic last);
        int r;
        int reach;
        logic signed [COORD_WIDTH-1:0] x, y;
        r = $urandom_range(0, 99);
        reach = 2 * sb.lookahead + 64;
        if (reach > 32767)
            reach = 32767;
        x = COORD_WIDTH'($urandom_range(0, reach));
        y = COORD_WIDTH'($signed($urandom_range(0, 2 * reach)) - reach);
        if (r < 10) begin
            send_point(1'b0, COORD_WIDTH'($urandom), COORD_WIDTH'($urandom), last);
            return;
        end
        if (r < 22)
            x = -$signed(16'($urandom_range(1, 32768)));
        else if (r < 37) begin
            x = COORD_WIDTH'($urandom);
            y = COORD_WIDTH'($urandom);
        end else if (r < 42)
            x = '0;
        send_point(1'b1, x, y, last);
    endtask

    task automatic run_phase(int items);
        int len;
        sent_in_phase = 0;
        while (sent_in_phase < items) begin
            if ($urandom_range(0, 19) == 0)
                steady = ~steady;
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_random_point(i == len - 1);
        end
        steady = 1'b0;
        drain();
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: run on reset register values first
        send_point(1'b0, 16'sd0, 16'sd0, 1'b1);          // empty trajectory
        send_point(1'b1, -16'sd1, 16'sd4000, 1'b0);      // behind the car, skip
        send_point(1'b1, 16'sd100, 16'sd100, 1'b0);      // inside lookahead
        send_point(1'b1, 16'sd0, 16'sd1537, 1'b0);       // zero forward, latched
        send_point(1'b1, 16'sd3000, -16'sd3000, 1'b1);   // ignored after latch
        send_point(1'b1, 16'sd1536, 16'sd0, 1'b1);       // exactly on circle, no target
        send_point(1'b1, 16'sd1537, 16'sd0, 1'b1);       // just past, straight ahead
        send_point(1'b1, 16'sd0, -16'sd1537, 1'b1);      // hard turn on last point
        send_point(1'b1, -16'sd32768, -16'sd32768, 1'b1);
        send_point(1'b1, 16'sd32767, 16'sd32767, 1'b1);
        send_point(1'b1, 16'sd32767, -16'sd32768, 1'b1);
        send_point(1'b1, 16'sd2000, 16'sd50, 1'b0);
        send_point(1'b0, 16'sd0, 16'sd0, 1'b1);          // empty marker ends a scan
        drain();

        // Extremes: zero lookahead, zero speed
        write_reg(ADDR_LOOKAHEAD, '0);
        write_reg(ADDR_CRUISE, '0);
        send_point(1'b1, 16'sd0, 16'sd0, 1'b1);          // zero distance, never found
        send_point(1'b1, 16'sd0, 16'sd1, 1'b1);
        send_point(1'b1, 16'sd1, -16'sd1, 1'b1);
        run_phase(PHASE_ITEMS);

        // Extremes: largest lookahead and speed
        write_reg(ADDR_LOOKAHEAD, 15'h7fff);
        write_reg(ADDR_CRUISE, 15'(12'hfff));
        send_point(1'b1, 16'sd32767, 16'sd1, 1'b1);
        send_point(1'b1, 16'sd32767, -16'sd32768, 1'b1);
        run_phase(PHASE_ITEMS);

        write_reg(ADDR_LOOKAHEAD, 15'd1536);
        write_reg(ADDR_CRUISE, 15'd700);
        run_phase(PHASE_ITEMS);

        repeat (2) begin
            write_reg(ADDR_LOOKAHEAD, LOOK_WIDTH'($urandom_range(0, 32767)));
            write_reg(ADDR_CRUISE, LOOK_WIDTH'($urandom_range(0, 4095)));
            run_phase(PHASE_ITEMS);
        end

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
